/* design/pic_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and status codes for the pedigree inbreeding block.
// No dependencies; used by pic_mul and pedigree_inbreeding_coefficient.
package pic_pkg;

	localparam int MAX_ANIMALS = 1024;
	localparam int ADDR_W      = $clog2(MAX_ANIMALS);
	localparam int IDX_W       = ADDR_W + 1;
	localparam int MAX_DEPTH   = 64;
	localparam int DEPTH_W     = $clog2(MAX_DEPTH);
	localparam int FRAC_BITS   = 30;
	localparam int F_W         = FRAC_BITS + 1;
	localparam int CONTRIB_W   = 32;
	localparam int MUL_W       = 32;
	localparam int ACC_W       = 64;

	localparam logic [F_W-1:0] ONE = F_W'(1) << FRAC_BITS;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [F_W-1:0]    fx_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_PARENT  = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_DEPTH   = 2'd3;

endpackage

/* design/pic_mul.sv */
`timescale 1ns / 1ps
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on pic_pkg for the operand width.
module pic_mul (
	input  logic                        clk,
	input  logic [pic_pkg::MUL_W-1:0]   a,
	input  logic [pic_pkg::MUL_W-1:0]   b,
	output logic [2*pic_pkg::MUL_W-1:0] p
);
	import pic_pkg::*;

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

/* design/pedigree_inbreeding_coefficient.sv */
`timescale 1ns / 1ps
// Pedigree inbreeding coefficient engine: sequencer, pedigree memories, walk.
// Depends on pic_pkg and pic_mul.
//
// Usage: animals enter in pedigree order on the in_valid/in_ready channel, one
// transfer each, with 1-based sire and dam indices (0 = unknown) and start_new
// to begin a fresh pedigree. Each animal yields one result on the
// out_valid/out_ready channel: its number, F in unsigned Q1.30 and a status.
// One animal is processed at a time; in_ready is high only while idle.
// The time from the input transfer to out_valid grows with the animal's LAP
// level, as one group counter is updated per level. When the ancestor walk
// runs, its time grows with the LAP groups checked and the ancestors visited;
// each ancestor takes memory read-modify-writes and two passes through the
// single shared multiplier, and a list slot with no valid animal is skipped.
// Unknown parent and full sib results skip the walk; a table-full result also
// skips the group update. The next item can be taken in the cycle after the
// result is loaded. After reset, and on every item with start_new set, a
// clearing pass zeroes all 1024 contribution store entries and the group
// counters before the item is processed. A result waiting on a stalled
// receiver is held in the output register; the next item may be taken
// meanwhile, but it cannot finish until that result has been transferred.
module pedigree_inbreeding_coefficient (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [pic_pkg::IDX_W-1:0] sire_index,
	input  logic [pic_pkg::IDX_W-1:0] dam_index,
	input  logic                    start_new,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [pic_pkg::IDX_W-1:0] animal_number,
	output logic [30:0]             inbreeding,
	output logic [1:0]              status
);
	import pic_pkg::*;

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_CHK   = 5'd2;
	localparam logic [4:0] S_PAR   = 5'd3;
	localparam logic [4:0] S_STORE = 5'd4;
	localparam logic [4:0] S_GRD   = 5'd5;
	localparam logic [4:0] S_GWR   = 5'd6;
	localparam logic [4:0] S_DEC   = 5'd7;
	localparam logic [4:0] S_WI    = 5'd8;
	localparam logic [4:0] S_WI2   = 5'd9;
	localparam logic [4:0] S_L0    = 5'd10;
	localparam logic [4:0] S_L1    = 5'd11;
	localparam logic [4:0] S_L2    = 5'd12;
	localparam logic [4:0] S_L3    = 5'd13;
	localparam logic [4:0] S_PSEL  = 5'd14;
	localparam logic [4:0] S_PRD   = 5'd15;
	localparam logic [4:0] S_PCHK  = 5'd16;
	localparam logic [4:0] S_PPUSH = 5'd17;
	localparam logic [4:0] S_M1    = 5'd18;
	localparam logic [4:0] S_M2    = 5'd19;
	localparam logic [4:0] S_M3    = 5'd20;
	localparam logic [4:0] S_FIN   = 5'd21;

	localparam int GRP_W = 2 * IDX_W;
	localparam int CQ_W  = CONTRIB_W + 1;
	localparam idx_t FULL_CNT = IDX_W'(MAX_ANIMALS);

	// memories
	idx_t                 sire_mem  [MAX_ANIMALS];
	idx_t                 dam_mem   [MAX_ANIMALS];
	logic [DEPTH_W-1:0]   depth_mem [MAX_ANIMALS];
	fx_t                  coef_mem  [MAX_ANIMALS];
	fx_t                  bterm_mem [MAX_ANIMALS];
	logic [CQ_W-1:0]      cq_mem    [MAX_ANIMALS];
	idx_t                 anc_mem   [MAX_ANIMALS];
	logic [GRP_W-1:0]     grp_mem   [MAX_DEPTH];

	// control state
	logic [4:0]         state_q;
	logic [ADDR_W-1:0]  ctr_q;
	logic               go_q;
	idx_t               count_q;
	idx_t               s_q, d_q;
	logic [1:0]         stat_q;
	logic [DEPTH_W-1:0] lap_q, g_q, t_q, pdep_q;
	fx_t                bterm_q;
	logic               kval_q;
	idx_t               j_q, js_q, jd_q;
	logic [CONTRIB_W-1:0] lj_q, cqv_q;
	fx_t                b_q;
	logic               psel_q;
	logic [1:0]         sh_q;
	logic [ACC_W-1:0]   acc_q;
	fx_t                f_q;
	logic               store_q;
	idx_t               prev_s_q, prev_d_q;
	fx_t                prev_f_q;
	logic               out_valid_q;
	idx_t               out_num_q;
	fx_t                out_f_q;
	logic [1:0]         out_stat_q;

	// memory ports
	logic               par_we;
	logic [DEPTH_W-1:0] dep_rd_a, dep_rd_b;
	addr_t              dep_ra_a, dep_ra_b;
	fx_t                coef_rd_a, coef_rd_b;
	logic               coef_we;
	addr_t              jr_a;
	idx_t               sire_rd, dam_rd;
	fx_t                bterm_rd;
	logic               cq_we;
	addr_t              cq_wa, cq_ra;
	logic [CQ_W-1:0]    cq_wd, cq_rd;
	logic               anc_we;
	addr_t              anc_wa, anc_ra;
	idx_t               anc_wd, anc_rd;
	logic               grp_we;
	logic [DEPTH_W-1:0] grp_wa, grp_ra;
	logic [GRP_W-1:0]   grp_wd, grp_rd;

	logic [MUL_W-1:0]   mul_a, mul_b;
	logic [2*MUL_W-1:0] prod;

	pic_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

	always_ff @(posedge clk) begin
		if (par_we) begin
			sire_mem[count_q[ADDR_W-1:0]]  <= s_q;
			dam_mem[count_q[ADDR_W-1:0]]   <= d_q;
			depth_mem[count_q[ADDR_W-1:0]] <= lap_q;
			bterm_mem[count_q[ADDR_W-1:0]] <= bterm_q;
		end
		dep_rd_a <= depth_mem[dep_ra_a];
		dep_rd_b <= depth_mem[dep_ra_b];
		sire_rd  <= sire_mem[jr_a];
		dam_rd   <= dam_mem[jr_a];
		bterm_rd <= bterm_mem[jr_a];
	end

	always_ff @(posedge clk) begin
		if (coef_we)
			coef_mem[ADDR_W'(count_q - 1'b1)] <= f_q;
		coef_rd_a <= coef_mem[dep_ra_a];
		coef_rd_b <= coef_mem[dep_ra_b];
	end

	always_ff @(posedge clk) begin
		if (cq_we)
			cq_mem[cq_wa] <= cq_wd;
		cq_rd <= cq_mem[cq_ra];
	end

	always_ff @(posedge clk) begin
		if (anc_we)
			anc_mem[anc_wa] <= anc_wd;
		anc_rd <= anc_mem[anc_ra];
	end

	always_ff @(posedge clk) begin
		if (grp_we)
			grp_mem[grp_wa] <= grp_wd;
		grp_rd <= grp_mem[grp_ra];
	end

	// datapath helpers
	idx_t s_chk, d_chk;
	logic [DEPTH_W:0] lap_a, lap_b, lap_x;
	logic ovf;
	idx_t s_n, d_n;
	logic [F_W-1:0] tb_a, tb_b;
	idx_t grp_start, grp_next, nk, par_p;
	logic par_ok;
	logic [CONTRIB_W-1:0] half;
	logic [32:0] shb;
	logic [65:0] total;
	logic [35:0] term;
	logic [ACC_W:0] acc_sum;
	logic [ACC_W-1:0] acc_m1;
	fx_t f_fin;

	assign s_chk = (s_q <= count_q) ? s_q : '0;
	assign d_chk = (d_q <= count_q) ? d_q : '0;
	assign lap_a = (s_q != '0) ? ({1'b0, dep_rd_a} + 1'b1) : '0;
	assign lap_b = (d_q != '0) ? ({1'b0, dep_rd_b} + 1'b1) : '0;
	assign lap_x = (lap_a > lap_b) ? lap_a : lap_b;
	assign ovf   = lap_x[DEPTH_W];
	assign s_n   = ovf ? '0 : s_q;
	assign d_n   = ovf ? '0 : d_q;
	assign tb_a  = (s_n != '0) ? F_W'(({1'b0, coef_rd_a} + {1'b0, ONE}) >> 2) : '0;
	assign tb_b  = (d_n != '0) ? F_W'(({1'b0, coef_rd_b} + {1'b0, ONE}) >> 2) : '0;

	assign grp_start = grp_rd[GRP_W-1:IDX_W];
	assign grp_next  = grp_rd[IDX_W-1:0];
	assign nk        = grp_next - 1'b1;
	assign par_p     = psel_q ? jd_q : js_q;
	assign par_ok    = (par_p != '0) && (par_p <= count_q);
	assign half      = lj_q >> 1;

	// high bits of the squared contribution times B, added beside the multiplier
	assign shb     = (sh_q[0] ? {2'b0, b_q} : 33'd0) + (sh_q[1] ? {1'b0, b_q, 1'b0} : 33'd0);
	assign total   = {2'b0, prod} + {1'b0, shb, 32'd0};
	assign term    = total[65:30];
	assign acc_sum = {1'b0, acc_q} + {29'd0, term};
	assign acc_m1  = acc_q - {33'd0, ONE};
	assign f_fin   = (acc_q < {33'd0, ONE}) ? '0 :
			 (acc_m1 > {33'd0, ONE}) ? ONE : F_W'(acc_m1);

	always_comb begin
		par_we   = 1'b0;
		coef_we  = 1'b0;
		dep_ra_a = ADDR_W'(s_chk - 1'b1);
		dep_ra_b = ADDR_W'(d_chk - 1'b1);
		jr_a     = ADDR_W'(anc_rd - 1'b1);
		cq_we    = 1'b0;
		cq_wa    = ctr_q;
		cq_wd    = '0;
		cq_ra    = ADDR_W'(anc_rd - 1'b1);
		anc_we   = 1'b0;
		anc_wa   = grp_next[ADDR_W-1:0];
		anc_wd   = count_q;
		anc_ra   = nk[ADDR_W-1:0];
		grp_we   = 1'b0;
		grp_wa   = g_q;
		grp_wd   = '0;
		grp_ra   = g_q;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			S_CLR: begin
				cq_we  = 1'b1;
				grp_we = (ctr_q < ADDR_W'(MAX_DEPTH));
				grp_wa = ctr_q[DEPTH_W-1:0];
			end
			S_STORE: par_we = 1'b1;
			S_GWR: begin
				grp_we = 1'b1;
				grp_wd = {grp_start + 1'b1, grp_next + 1'b1};
			end
			S_WI: grp_ra = lap_q;
			S_WI2: begin
				cq_we = 1'b1;
				cq_wa = ADDR_W'(count_q - 1'b1);
				if (grp_next < FULL_CNT) begin
					anc_we = 1'b1;
					grp_we = 1'b1;
					grp_wa = lap_q;
					grp_wd = {grp_start, grp_next + 1'b1};
					cq_wd  = {1'b1, CONTRIB_W'(ONE)};
				end else begin
					cq_wd  = {1'b0, CONTRIB_W'(ONE)};
				end
			end
			S_L0: grp_ra = t_q;
			S_L1: begin
				if (grp_next > grp_start) begin
					grp_we = 1'b1;
					grp_wa = t_q;
					grp_wd = {grp_start, nk};
				end
			end
			S_PRD: begin
				dep_ra_a = ADDR_W'(par_p - 1'b1);
				cq_ra    = ADDR_W'(par_p - 1'b1);
			end
			S_PCHK: begin
				grp_ra = dep_rd_a;
				if (cq_rd[CONTRIB_W]) begin
					cq_we = 1'b1;
					cq_wa = ADDR_W'(par_p - 1'b1);
					cq_wd = {1'b1, cq_rd[CONTRIB_W-1:0] + half};
				end
			end
			S_PPUSH: begin
				cq_we  = 1'b1;
				cq_wa  = ADDR_W'(par_p - 1'b1);
				anc_wd = par_p;
				if (grp_next < FULL_CNT) begin
					anc_we = 1'b1;
					grp_we = 1'b1;
					grp_wa = pdep_q;
					grp_wd = {grp_start, grp_next + 1'b1};
					cq_wd  = {1'b1, cqv_q + half};
				end else begin
					cq_wd  = {1'b0, cqv_q + half};
				end
			end
			S_M1: begin
				mul_a = lj_q;
				mul_b = lj_q;
			end
			S_M2: begin
				mul_a = prod[61:30];
				mul_b = {1'b0, b_q};
			end
			S_M3: begin
				cq_we = 1'b1;
				cq_wa = ADDR_W'(j_q - 1'b1);
			end
			S_FIN: coef_we = store_q && !(out_valid_q && !out_ready);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ctr_q       <= '0;
			go_q        <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			psel_q      <= 1'b0;
			store_q     <= 1'b0;
		end else begin
			// in S_FIN a drained register is reloaded below
			if (out_valid_q && out_ready && state_q != S_FIN)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					count_q <= '0;
					ctr_q   <= ctr_q + 1'b1;
					if (ctr_q == '1)
						state_q <= go_q ? S_CHK : S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						s_q <= sire_index;
						d_q <= dam_index;
						if (start_new) begin
							go_q    <= 1'b1;
							ctr_q   <= '0;
							state_q <= S_CLR;
						end else begin
							state_q <= S_CHK;
						end
					end
				end
				S_CHK: begin
					go_q <= 1'b0;
					if (count_q == FULL_CNT) begin
						store_q <= 1'b0;
						f_q     <= '0;
						stat_q  <= ST_FULL;
						state_q <= S_FIN;
					end else begin
						store_q <= 1'b1;
						s_q     <= s_chk;
						d_q     <= d_chk;
						stat_q  <= (s_chk != s_q || d_chk != d_q) ? ST_PARENT : ST_OK;
						state_q <= S_PAR;
					end
				end
				S_PAR: begin
					s_q     <= s_n;
					d_q     <= d_n;
					lap_q   <= ovf ? '0 : lap_x[DEPTH_W-1:0];
					bterm_q <= ONE - tb_a - tb_b;
					if (ovf && stat_q == ST_OK)
						stat_q <= ST_DEPTH;
					state_q <= S_STORE;
				end
				S_STORE: begin
					count_q <= count_q + 1'b1;
					g_q     <= '0;
					state_q <= (lap_q == '0) ? S_DEC : S_GRD;
				end
				S_GRD: state_q <= S_GWR;
				S_GWR: begin
					g_q     <= g_q + 1'b1;
					state_q <= (g_q == lap_q - 1'b1) ? S_DEC : S_GRD;
				end
				S_DEC: begin
					if (s_q == '0 || d_q == '0) begin
						f_q     <= '0;
						state_q <= S_FIN;
					end else if (count_q > IDX_W'(1) && s_q == prev_s_q && d_q == prev_d_q) begin
						f_q     <= prev_f_q;
						state_q <= S_FIN;
					end else begin
						state_q <= S_WI;
					end
				end
				S_WI: state_q <= S_WI2;
				S_WI2: begin
					t_q     <= lap_q;
					acc_q   <= '0;
					state_q <= S_L0;
				end
				S_L0: state_q <= S_L1;
				S_L1: begin
					if (grp_next <= grp_start) begin
						if (t_q == '0) begin
							f_q     <= f_fin;
							state_q <= S_FIN;
						end else begin
							t_q     <= t_q - 1'b1;
							state_q <= S_L0;
						end
					end else begin
						kval_q  <= (nk < FULL_CNT);
						state_q <= S_L2;
					end
				end
				S_L2: begin
					// a slot past the end of the list reads as unknown
					if (kval_q && anc_rd != '0 && anc_rd <= count_q) begin
						j_q     <= anc_rd;
						state_q <= S_L3;
					end else begin
						state_q <= S_L0;
					end
				end
				S_L3: begin
					js_q    <= sire_rd;
					jd_q    <= dam_rd;
					b_q     <= bterm_rd;
					lj_q    <= cq_rd[CONTRIB_W-1:0];
					psel_q  <= 1'b0;
					state_q <= S_PSEL;
				end
				S_PSEL: begin
					if (par_ok)
						state_q <= S_PRD;
					else if (!psel_q)
						psel_q <= 1'b1;
					else
						state_q <= S_M1;
				end
				S_PRD: state_q <= S_PCHK;
				S_PCHK: begin
					if (cq_rd[CONTRIB_W]) begin
						if (psel_q) begin
							state_q <= S_M1;
						end else begin
							psel_q  <= 1'b1;
							state_q <= S_PSEL;
						end
					end else begin
						cqv_q   <= cq_rd[CONTRIB_W-1:0];
						pdep_q  <= dep_rd_a;
						state_q <= S_PPUSH;
					end
				end
				S_PPUSH: begin
					if (psel_q) begin
						state_q <= S_M1;
					end else begin
						psel_q  <= 1'b1;
						state_q <= S_PSEL;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: begin
					sh_q    <= prod[63:62];
					state_q <= S_M3;
				end
				S_M3: begin
					acc_q   <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
					state_q <= S_L0;
				end
				S_FIN: begin
					if (!(out_valid_q && !out_ready)) begin
						out_valid_q <= 1'b1;
						out_num_q   <= store_q ? count_q : '0;
						out_f_q     <= f_q;
						out_stat_q  <= stat_q;
						if (store_q) begin
							prev_s_q <= s_q;
							prev_d_q <= d_q;
							prev_f_q <= f_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = out_valid_q;
	assign animal_number = out_num_q;
	assign inbreeding    = out_f_q;
	assign status        = out_stat_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("animal count beyond table size");

	a_full_number: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> animal_number == '0)
		else $error("table-full result carries an animal number");

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inbreeding <= ONE)
		else $error("coefficient above one");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR && ctr_q != '1) |=> !in_ready)
		else $error("input taken during clearing pass");

endmodule
